>>> hdl/nine_bit_multidrop_frame_tx_unit_assert.svh
// Assertion helpers shared by the frame transmitter modules.
// Each macro expects aclk and aresetn in scope.
`ifndef NINE_BIT_MULTIDROP_FRAME_TX_UNIT_ASSERT_SVH
`define NINE_BIT_MULTIDROP_FRAME_TX_UNIT_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define FMTX_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define FMTX_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define FMTX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/fmtx_pkg.sv
`timescale 1ns / 1ps
package fmtx_pkg;

    localparam int unsigned ByteW     = 8;
    localparam int unsigned LineW     = 12;
    localparam int unsigned WordIdxW  = 3;
    localparam logic [ByteW-1:0] HeaderExtra = 8'd5;
    localparam logic [ByteW-1:0] ZeroByte    = 8'h00;
    localparam logic [1:0]       IdleBits    = 2'b11;

    // Word positions within the expansion of one item
    localparam logic [WordIdxW-1:0] WORD_DEST  = 3'd0;
    localparam logic [WordIdxW-1:0] WORD_OWN   = 3'd1;
    localparam logic [WordIdxW-1:0] WORD_ZERO  = 3'd2;
    localparam logic [WordIdxW-1:0] WORD_TOTAL = 3'd3;
    localparam logic [WordIdxW-1:0] WORD_DATA  = 3'd4;
    localparam logic [WordIdxW-1:0] WORD_CKSUM = 3'd5;

    typedef struct packed {
        logic [ByteW-1:0] dest;
        logic [ByteW-1:0] own;
        logic [ByteW-1:0] total;
        logic [ByteW-1:0] data;
        logic [ByteW-1:0] cksum;
        logic             header;
        logic             ends;
    } fmtx_job_t;

    function automatic logic [LineW-1:0] line_pattern(input logic [ByteW-1:0] b,
                                                      input logic flag);
        line_pattern = {IdleBits, flag, b, 1'b0};
    endfunction

endpackage

>>> hdl/fmtx_builder.sv
`timescale 1ns / 1ps
`include "nine_bit_multidrop_frame_tx_unit_assert.svh"
module fmtx_builder import fmtx_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [ByteW-1:0] cfg_wr_data,
    input  logic             accept,
    input  logic [ByteW-1:0] dest_address,
    input  logic [ByteW-1:0] payload_length,
    input  logic [ByteW-1:0] payload_byte,
    output fmtx_job_t        job
);

    logic             in_packet_reg, in_packet_next;
    logic [ByteW-1:0] bytes_left_reg, bytes_left_next;
    logic [ByteW-1:0] running_sum_reg, running_sum_next;
    logic [ByteW-1:0] own_address_reg;

    logic [ByteW-1:0] len_eff;
    logic [ByteW-1:0] total;
    logic [ByteW-1:0] sum_head;
    logic [ByteW-1:0] left;
    logic [ByteW-1:0] left_after;

    always_comb begin
        len_eff    = (payload_length == ZeroByte) ? 8'd1 : payload_length;
        total      = len_eff + HeaderExtra;
        sum_head   = in_packet_reg ? running_sum_reg : (dest_address + own_address_reg + total);
        left       = in_packet_reg ? bytes_left_reg : len_eff;
        left_after = left - 8'd1;

        job.dest   = dest_address;
        job.own    = own_address_reg;
        job.total  = total;
        job.data   = payload_byte;
        job.cksum  = sum_head + payload_byte;
        job.header = !in_packet_reg;
        job.ends   = (left_after == ZeroByte);

        in_packet_next   = in_packet_reg;
        bytes_left_next  = bytes_left_reg;
        running_sum_next = running_sum_reg;
        if (accept) begin
            if (job.ends) begin
                in_packet_next   = 1'b0;
                bytes_left_next  = ZeroByte;
                running_sum_next = ZeroByte;
            end else begin
                in_packet_next   = 1'b1;
                bytes_left_next  = left_after;
                running_sum_next = job.cksum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_packet_reg   <= 1'b0;
            bytes_left_reg  <= ZeroByte;
            running_sum_reg <= ZeroByte;
            own_address_reg <= ZeroByte;
        end else begin
            in_packet_reg   <= in_packet_next;
            bytes_left_reg  <= bytes_left_next;
            running_sum_reg <= running_sum_next;
            if (cfg_wr_en) begin
                own_address_reg <= cfg_wr_data;
            end
        end
    end

    // Between packets the counters sit at zero
    `FMTX_ASSERT_IMPLY(a_idle_clear, !in_packet_reg,
        (bytes_left_reg == ZeroByte) && (running_sum_reg == ZeroByte),
        "builder counters not cleared between packets")

endmodule

>>> hdl/fmtx_seq.sv
`timescale 1ns / 1ps
`include "nine_bit_multidrop_frame_tx_unit_assert.svh"
module fmtx_seq import fmtx_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  fmtx_job_t        job,
    output logic             job_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [ByteW-1:0] m_symbol_byte,
    output logic             m_address_flag,
    output logic [LineW-1:0] m_line_frame,
    output logic             m_frame_end,
    output logic             m_last_of_run
);

    fmtx_job_t           job_reg;
    logic                job_valid_reg;
    logic [WordIdxW-1:0] idx_reg;

    logic             m_valid_reg;
    logic [ByteW-1:0] m_symbol_byte_reg;
    logic             m_address_flag_reg;
    logic [LineW-1:0] m_line_frame_reg;
    logic             m_frame_end_reg;
    logic             m_last_of_run_reg;

    logic             load;
    logic             last;
    logic [ByteW-1:0] word_byte;
    logic             word_flag;

    always_comb begin
        load = job_valid_reg && (!m_valid_reg || m_ready);
        last = (idx_reg == (job_reg.ends ? WORD_CKSUM : WORD_DATA));
        word_flag = 1'b0;
        case (idx_reg)
            WORD_DEST: begin
                word_byte = job_reg.dest;
                word_flag = 1'b1;
            end
            WORD_OWN:   word_byte = job_reg.own;
            WORD_ZERO:  word_byte = ZeroByte;
            WORD_TOTAL: word_byte = job_reg.total;
            WORD_DATA:  word_byte = job_reg.data;
            WORD_CKSUM: word_byte = job_reg.cksum;
            default:    word_byte = ZeroByte;
        endcase
        // Free the slot as the last word of the current item leaves
        job_ready = !job_valid_reg || (load && last);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            idx_reg       <= WORD_DEST;
            m_valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                job_valid_reg <= 1'b1;
                idx_reg       <= job.header ? WORD_DEST : WORD_DATA;
            end else if (load) begin
                if (last) begin
                    job_valid_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + 3'd1;
                end
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            job_reg <= job;
        end
        if (load) begin
            m_symbol_byte_reg  <= word_byte;
            m_address_flag_reg <= word_flag;
            m_line_frame_reg   <= line_pattern(word_byte, word_flag);
            m_frame_end_reg    <= (idx_reg == WORD_CKSUM);
            m_last_of_run_reg  <= last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_symbol_byte  = m_symbol_byte_reg;
    assign m_address_flag = m_address_flag_reg;
    assign m_line_frame   = m_line_frame_reg;
    assign m_frame_end    = m_frame_end_reg;
    assign m_last_of_run  = m_last_of_run_reg;

    `FMTX_ASSERT(a_idx_range, !job_valid_reg || (idx_reg <= WORD_CKSUM),
        "word index beyond checksum position")
    `FMTX_ASSERT_IMPLY(a_cksum_only_at_end, job_valid_reg && !job_reg.ends,
        idx_reg != WORD_CKSUM, "checksum word scheduled on a non-final item")
    `FMTX_ASSERT_IMPLY(a_end_is_last, m_valid_reg && m_frame_end_reg,
        m_last_of_run_reg && !m_address_flag_reg, "checksum word not closing its item")
    `FMTX_ASSERT_NEXT(a_dest_then_own, load && (idx_reg == WORD_DEST),
        job_valid_reg && (idx_reg == WORD_OWN), "header did not advance past destination")

endmodule

>>> hdl/nine_bit_multidrop_frame_tx_unit.sv
`timescale 1ns / 1ps
// Nine-bit multidrop frame transmitter.
// Input channel (s_valid/s_ready) takes one payload byte per item; on the
// first byte of a packet dest_address and payload_length are sampled too.
// Output channel (m_valid/m_ready) gives one bus word per transfer: data byte,
// ninth (address) bit, the 12-bit line pattern, a packet-end flag on the
// checksum word and a flag on the last word caused by each input item.
// The first byte of a packet expands to five words (six for a one-byte
// packet), later bytes to one word (two for the final byte).
// The first word of an accepted item passes the expansion register, then
// the output register. Throughput: one word per cycle while m_ready is
// high; a one-slot expansion register ahead of the output register lets
// the next item be accepted in the cycle its predecessor's last word
// leaves.
// own_address is written through cfg_wr_en/cfg_wr_data and read when a
// packet's first byte is accepted.
// Reset (aresetn low, synchronous) empties both stages and returns to the
// between-packets state with own_address at zero.
// When m_ready is low the output word holds and s_ready drops once the
// expansion register is occupied.
module nine_bit_multidrop_frame_tx_unit import fmtx_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [ByteW-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [ByteW-1:0] s_dest_address,
    input  logic [ByteW-1:0] s_payload_length,
    input  logic [ByteW-1:0] s_payload_byte,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [ByteW-1:0] m_symbol_byte,
    output logic             m_address_flag,
    output logic [LineW-1:0] m_line_frame,
    output logic             m_frame_end,
    output logic             m_last_of_run
);

    fmtx_job_t job;
    logic      job_ready;
    logic      accept;

    assign s_ready = job_ready;
    assign accept  = s_valid && job_ready;

    fmtx_builder u_builder (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .accept         (accept),
        .dest_address   (s_dest_address),
        .payload_length (s_payload_length),
        .payload_byte   (s_payload_byte),
        .job            (job)
    );

    fmtx_seq u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .job            (job),
        .job_ready      (job_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_symbol_byte  (m_symbol_byte),
        .m_address_flag (m_address_flag),
        .m_line_frame   (m_line_frame),
        .m_frame_end    (m_frame_end),
        .m_last_of_run  (m_last_of_run)
    );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import fmtx_pkg::*;

    localparam int unsigned StallLimit = 2000;

    typedef struct {
        logic [ByteW-1:0] symbol;
        logic             flag;
        logic [LineW-1:0] line;
        logic             fend;
        logic             last;
    } bus_word_t;

    class frame_scoreboard;
        logic [ByteW-1:0] own_addr;
        bit               in_pkt;
        logic [ByteW-1:0] remaining;
        logic [ByteW-1:0] cksum;
        bus_word_t        words_due[$];
        int unsigned      errors;
        int unsigned      words_checked;
        int unsigned      packets_done;

        function new();
            own_addr      = '0;
            in_pkt        = 1'b0;
            remaining     = '0;
            cksum         = '0;
            errors        = 0;
            words_checked = 0;
            packets_done  = 0;
        endfunction

        function void add_word(logic [ByteW-1:0] b, logic flag, logic fend);
            bus_word_t w;
            w.symbol = b;
            w.flag   = flag;
            w.line   = {IdleBits, flag, b, 1'b0};
            w.fend   = fend;
            w.last   = 1'b0;
            words_due.push_back(w);
        endfunction

        // Expand one accepted item into the bus words it produces.
        function void note_item(logic [ByteW-1:0] dest, logic [ByteW-1:0] len,
                                logic [ByteW-1:0] data);
            logic [ByteW-1:0] count;
            logic [ByteW-1:0] total;
            if (!in_pkt) begin
                count = (len == '0) ? 8'd1 : len;
                total = count + HeaderExtra;
                add_word(dest, 1'b1, 1'b0);
                add_word(own_addr, 1'b0, 1'b0);
                add_word(ZeroByte, 1'b0, 1'b0);
                add_word(total, 1'b0, 1'b0);
                cksum     = dest + own_addr + total;
                remaining = count;
                in_pkt    = 1'b1;
            end
            add_word(data, 1'b0, 1'b0);
            cksum     = cksum + data;
            remaining = remaining - 8'd1;
            if (remaining == '0) begin
                add_word(cksum, 1'b0, 1'b1);
                in_pkt = 1'b0;
                cksum  = '0;
                packets_done++;
            end
            words_due[words_due.size() - 1].last = 1'b1;
        endfunction

        function void check_word(bus_word_t got);
            bus_word_t want;
            if (words_due.size() == 0) begin
                if (errors < 10)
                    $display("[%0t] unexpected word: byte=%02h flag=%b line=%03h end=%b last=%b",
                             $time, got.symbol, got.flag, got.line, got.fend, got.last);
                errors++;
                return;
            end
            want = words_due.pop_front();
            words_checked++;
            if (got.symbol !== want.symbol || got.flag !== want.flag ||
                got.line !== want.line || got.fend !== want.fend ||
                got.last !== want.last) begin
                if (errors < 10) begin
                    $display("[%0t] word mismatch #%0d", $time, words_checked);
                    $display("    expected byte=%02h flag=%b line=%03h end=%b last=%b",
                             want.symbol, want.flag, want.line, want.fend, want.last);
                    $display("    actual   byte=%02h flag=%b line=%03h end=%b last=%b",
                             got.symbol, got.flag, got.line, got.fend, got.last);
                end
                errors++;
            end
        endfunction
    endclass

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [ByteW-1:0] cfg_wr_data = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [ByteW-1:0] s_dest_address = '0;
    logic [ByteW-1:0] s_payload_length = '0;
    logic [ByteW-1:0] s_payload_byte = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [ByteW-1:0] m_symbol_byte;
    logic             m_address_flag;
    logic [LineW-1:0] m_line_frame;
    logic             m_frame_end;
    logic             m_last_of_run;

    frame_scoreboard sb;
    int unsigned     items_sent = 0;
    int unsigned     long_packets = 0;
    int unsigned     addr_settings = 0;
    int unsigned     burst_left = 1;
    bit              no_gaps = 1'b0;
    int unsigned     quiet_cycles = 0;
    logic [7:0]      ready_tick = '0;
    logic [1:0]      ready_mode = '0;

    nine_bit_multidrop_frame_tx_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_dest_address   (s_dest_address),
        .s_payload_length (s_payload_length),
        .s_payload_byte   (s_payload_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_symbol_byte    (m_symbol_byte),
        .m_address_flag   (m_address_flag),
        .m_line_frame     (m_line_frame),
        .m_frame_end      (m_frame_end),
        .m_last_of_run    (m_last_of_run)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Receiver back-pressure: switch pattern whenever the low six bits of ready_tick are zero.
    always @(negedge aclk) begin
        ready_tick <= ready_tick + 8'd1;
        if (ready_tick[5:0] == 6'd0)
            ready_mode <= 2'($urandom_range(0, 3));
        case (ready_mode)
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= ($urandom_range(0, 9) < 7);
            2'd2: m_ready <= (ready_tick[2:0] != 3'd0);
            default: m_ready <= (ready_tick[4:0] >= 5'd12);
        endcase
    end

    always @(posedge aclk) begin
        bus_word_t got;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            got.symbol = m_symbol_byte;
            got.flag   = m_address_flag;
            got.line   = m_line_frame;
            got.fend   = m_frame_end;
            got.last   = m_last_of_run;
            sb.check_word(got);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid === 1'b1 && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < StallLimit) @(posedge aclk);
        $display("watchdog: no handshake for %0d cycles", StallLimit);
        $display("FAIL nine_bit_multidrop_frame_tx_unit");
        $finish;
    end

    // Present one item and hold it until accepted; returns at a falling edge.
    task automatic send_item(input logic [ByteW-1:0] dest, input logic [ByteW-1:0] len,
                             input logic [ByteW-1:0] data);
        s_valid          <= 1'b1;
        s_dest_address   <= dest;
        s_payload_length <= len;
        s_payload_byte   <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_item(dest, len, data);
        items_sent++;
        @(negedge aclk);
        if (!no_gaps) begin
            burst_left--;
            if (burst_left == 0) begin
                int unsigned gap;
                gap = $urandom_range(0, 6);
                burst_left = $urandom_range(1, 12);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
        end
    endtask

    // Hold off the sender until every expected word has left.
    task automatic drain_words();
        s_valid <= 1'b0;
        while (sb.words_due.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_own_address(input logic [ByteW-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.own_addr = value;
        addr_settings++;
    endtask

    // Later bytes carry random dest/length fields that the block must ignore.
    task automatic send_packet(input logic [ByteW-1:0] dest, input logic [ByteW-1:0] len);
        int unsigned count;
        count = (len == '0) ? 1 : len;
        send_item(dest, len, 8'($urandom));
        for (int unsigned i = 1; i < count; i++)
            send_item(8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic random_phase(input int unsigned budget);
        int unsigned start;
        int unsigned pick;
        logic [ByteW-1:0] dest;
        logic [ByteW-1:0] len;
        start = items_sent;
        while (items_sent - start < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                len = 8'd0;
            else if (pick < 60)
                len = 8'($urandom_range(1, 3));
            else if (pick < 90)
                len = 8'($urandom_range(4, 8));
            else
                len = 8'($urandom_range(9, 20));
            pick = $urandom_range(0, 9);
            dest = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
            send_packet(dest, len);
        end
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: zero length, one-byte packets, field extremes, checksum wrap.
        no_gaps = 1'b1;
        write_own_address(8'h00);
        send_item(8'h00, 8'd0, 8'h00);
        send_item(8'hFF, 8'd1, 8'hFF);
        send_item(8'h80, 8'd2, 8'h01);
        send_item(8'hFF, 8'hFF, 8'hFE);
        send_item(8'h01, 8'd4, 8'h55);
        send_item(8'h00, 8'h00, 8'hAA);
        send_item(8'hFF, 8'hFF, 8'h00);
        send_item(8'h7F, 8'h7F, 8'hFF);
        drain_words();
        write_own_address(8'hFF);
        send_item(8'hFF, 8'd1, 8'hFF);
        send_item(8'h5A, 8'd3, 8'h80);
        send_item(8'h00, 8'h00, 8'h7F);
        send_item(8'h00, 8'h00, 8'hFF);
        send_item(8'hA5, 8'd0, 8'h5A);
        drain_words();

        no_gaps = 1'b0;
        write_own_address(8'($urandom_range(1, 254)));
        random_phase(50);
        drain_words();
        write_own_address(8'hFF);
        random_phase(50);
        drain_words();
        write_own_address(8'($urandom));
        no_gaps = 1'b1;
        random_phase(40);
        no_gaps = 1'b0;
        random_phase(30);
        drain_words();
        write_own_address(8'h00);
        random_phase(40);
        drain_words();

        // A length above 250 wraps the total byte; stop partway into that packet.
        send_item(8'($urandom), 8'($urandom_range(251, 255)), 8'($urandom));
        repeat (20) send_item(8'($urandom), 8'($urandom), 8'($urandom));
        long_packets++;

        drain_words();
        repeat (10) @(negedge aclk);
        if (sb.words_due.size() != 0) begin
            $display("%0d expected words never arrived", sb.words_due.size());
            sb.errors++;
        end
        $display("Sent %0d items in %0d packets plus %0d wrapped-length header, %0d bus words",
                 items_sent, sb.packets_done, long_packets, sb.words_checked);
        $display("across %0d own-address settings; %0d errors", addr_settings, sb.errors);
        if (sb.errors == 0)
            $display("PASS nine_bit_multidrop_frame_tx_unit");
        else
            $display("FAIL nine_bit_multidrop_frame_tx_unit");
        $finish;
    end

endmodule
